/* rtl/core/plb_pkg.sv */
// Shared types and constants for the positional list buffer.
package plb_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);

    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic signed [VALUE_W-1:0] VALUE_LIMIT = 32'sd2000000000;

    typedef enum logic [CMD_W-1:0] {
        CMD_APPEND     = 3'd0,
        CMD_PREPEND    = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_REMOVE_AT  = 3'd3,
        CMD_INSERT_AT  = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 3'd0,
        ST_RANGE = 3'd1,
        ST_POS   = 3'd2,
        ST_EMPTY = 3'd3,
        ST_FULL  = 3'd4
    } status_t;

    // Update request from the command decoder to the entry cells.
    typedef struct packed {
        logic                      insert;
        logic                      remove;
        logic [IDX_W-1:0]          index;
        logic signed [VALUE_W-1:0] value;
    } plb_ctrl_t;

endpackage

/* rtl/core/plb_if.sv */
// Valid/ready channel interfaces for commands and results.
interface plb_req_if
    import plb_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [CMD_W-1:0]          cmd;
    logic signed [VALUE_W-1:0] item_value;
    logic [POS_W-1:0]          item_position;

    modport source (output valid, output cmd, output item_value, output item_position,
                    input ready);
    modport sink   (input valid, input cmd, input item_value, input item_position,
                    output ready);
endinterface

interface plb_rsp_if
    import plb_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] removed_value;
    logic [COUNT_W-1:0]        entry_count;

    modport source (output valid, output status, output removed_value, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input removed_value, input entry_count,
                    output ready);
endinterface

/* rtl/core/plb_cells.sv */
// Row of entry cells that shift in parallel on insert and remove.
module plb_cells
    import plb_pkg::*;
(
    input  logic                      clk,
    input  plb_ctrl_t                 ctrl,
    output logic signed [VALUE_W-1:0] rd_value
);

    logic signed [VALUE_W-1:0] entry_reg  [CAPACITY];
    logic signed [VALUE_W-1:0] entry_next [CAPACITY];

    assign rd_value = entry_reg[ctrl.index];

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            entry_next[i] = entry_reg[i];
            if (ctrl.insert)
            begin
                if (IDX_W'(i) == ctrl.index)
                    entry_next[i] = ctrl.value;
                else if (i > 0 && IDX_W'(i) > ctrl.index)
                    entry_next[i] = entry_reg[(i > 0) ? i - 1 : 0];
            end
            else if (ctrl.remove)
            begin
                // last cell keeps its value; it falls outside the count anyway
                if (i < CAPACITY - 1 && IDX_W'(i) >= ctrl.index)
                    entry_next[i] = entry_reg[(i < CAPACITY - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
            entry_reg[i] <= entry_next[i];
    end

endmodule

/* rtl/core/positional_list_buffer.sv */
// Positional list buffer: ordered list of signed values with insert/remove at a position.
//
// Usage:
//   request channel carries one command per transaction: append, prepend,
//   remove front, remove at item_position, or insert at item_position.
//   result channel returns one transaction per command: status, the removed
//   value (zero unless a removal succeeded) and the entry count afterward.
//   The result is registered at the edge that takes the command.
//   Throughput is one command per cycle while the result register is empty
//   or being drained; all entry cells shift toward their neighbor in parallel
//   within that cycle, and the single output register sets the figure.
//   The list holds up to CAPACITY entries; inserts into a full list report
//   full. Values outside +/-2e9 are rejected.
//   Reset empties the list (count zero) and drops any pending result.
//   When the receiver stalls the result register holds, and a new command
//   is taken only in a cycle where that register is empty or being drained.
module positional_list_buffer
    import plb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    plb_req_if.sink   request,
    plb_rsp_if.source result
);

    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      valid_reg;
    logic [STATUS_W-1:0]       status_reg;
    logic signed [VALUE_W-1:0] removed_reg;
    logic [COUNT_W-1:0]        entry_count_reg;

    logic                      accept;
    logic                      value_ok;
    logic [CMP_W-1:0]          cnt_ext, pos_ext, tpos;
    logic                      do_insert, do_remove;
    status_t                   status;
    plb_ctrl_t                 ctrl;
    logic signed [VALUE_W-1:0] rd_value;

    assign request.ready = !valid_reg || result.ready;
    assign accept        = request.valid && request.ready;

    assign value_ok = (request.item_value >= -VALUE_LIMIT) && (request.item_value <= VALUE_LIMIT);
    assign cnt_ext  = CMP_W'(count_reg);
    assign pos_ext  = CMP_W'(request.item_position);

    always_comb
    begin
        do_insert = 1'b0;
        do_remove = 1'b0;
        status    = ST_OK;
        tpos      = pos_ext;
        unique case (request.cmd)
            CMD_APPEND, CMD_PREPEND, CMD_INSERT_AT:
            begin
                if (request.cmd == CMD_APPEND)
                    tpos = cnt_ext;
                else if (request.cmd == CMD_PREPEND)
                    tpos = '0;
                if (!value_ok)
                    status = ST_RANGE;
                else if (tpos > cnt_ext)
                    status = ST_POS;
                else if (cnt_ext == CMP_W'(CAPACITY))
                    status = ST_FULL;
                else
                    do_insert = 1'b1;
            end
            CMD_POP_FRONT, CMD_REMOVE_AT:
            begin
                if (request.cmd == CMD_POP_FRONT)
                    tpos = '0;
                if (count_reg == '0)
                    status = ST_EMPTY;
                else if (tpos >= cnt_ext)
                    status = ST_POS;
                else
                    do_remove = 1'b1;
            end
            default:
            begin
                // unknown commands leave the list alone and report ok
                status = ST_OK;
            end
        endcase
    end

    assign ctrl.insert = accept && do_insert;
    assign ctrl.remove = accept && do_remove;
    assign ctrl.index  = tpos[IDX_W-1:0];
    assign ctrl.value  = request.item_value;

    plb_cells u_cells (
        .clk      (clk),
        .ctrl     (ctrl),
        .rd_value (rd_value)
    );

    always_comb
    begin
        count_next = count_reg;
        if (ctrl.insert)
            count_next = count_reg + CNT_W'(1);
        else if (ctrl.remove)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
                valid_reg <= 1'b1;
            else if (result.ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg      <= status;
            removed_reg     <= do_remove ? rd_value : '0;
            entry_count_reg <= COUNT_W'(count_next);
        end
    end

    assign result.valid         = valid_reg;
    assign result.status        = status_reg;
    assign result.removed_value = removed_reg;
    assign result.entry_count   = entry_count_reg;

endmodule

/* bench/positional_list_buffer_tb.sv */
// Self-checking bench for the positional list buffer: directed and random list commands.
`timescale 1ns / 100ps

module positional_list_buffer_tb
    import plb_pkg::*;
;

    localparam logic signed [VALUE_W-1:0] MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam logic signed [VALUE_W-1:0] MOST_POS = {1'b0, {(VALUE_W-1){1'b1}}};
    localparam logic [POS_W-1:0]          POS_MAX  = '1;
    // cmd codes past the last defined one are ignored by the block
    localparam logic [CMD_W-1:0]          CMD_SPARE_LO = CMD_W'(int'(CMD_INSERT_AT) + 1);
    localparam logic [CMD_W-1:0]          CMD_SPARE_HI = '1;
    localparam int                        HOLD_LEN     = 300;
    localparam int                        DRAIN_LIMIT  = 5000;

    typedef struct {
        status_t                   status;
        logic signed [VALUE_W-1:0] removed;
        logic [COUNT_W-1:0]        entries_left;
    } list_reply_t;

    logic clk;
    logic rst_n;

    plb_req_if request_ch();
    plb_rsp_if result_ch();

    positional_list_buffer u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request_ch),
        .result  (result_ch)
    );

    logic signed [VALUE_W-1:0] shadow_list[$];
    list_reply_t               replies_due[$];
    list_reply_t               reply_seen;
    int                        error_count   = 0;
    bit                        sender_gaps   = 1'b1;
    bit                        receiver_gaps = 1'b1;
    int                        hold_request  = 0;
    int                        hold_len;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("positional_list_buffer_tb: errors");
        $finish;
    end

    task automatic report_mismatch(input string what);
        error_count++;
        if (error_count <= 40)
            $display("[%0t] MISMATCH %s", $time, what);
    endtask

    // ---------------------------------------------------------------- shadow list
    function automatic status_t place_value(input int pos, input logic signed [VALUE_W-1:0] v);
        // value check first, then position, then capacity
        if (v < -VALUE_LIMIT || v > VALUE_LIMIT)
            return ST_RANGE;
        if (pos > shadow_list.size())
            return ST_POS;
        if (shadow_list.size() >= CAPACITY)
            return ST_FULL;
        shadow_list.insert(pos, v);
        return ST_OK;
    endfunction

    function automatic status_t take_value(input int pos,
                                           output logic signed [VALUE_W-1:0] taken);
        taken = '0;
        if (shadow_list.size() == 0)
            return ST_EMPTY;
        if (pos >= shadow_list.size())
            return ST_POS;
        taken = shadow_list[pos];
        shadow_list.delete(pos);
        return ST_OK;
    endfunction

    function automatic list_reply_t step_shadow_list(input logic [CMD_W-1:0] c,
                                                     input logic signed [VALUE_W-1:0] v,
                                                     input logic [POS_W-1:0] p);
        list_reply_t r;
        r.status  = ST_OK;
        r.removed = '0;
        case (c)
            CMD_APPEND:    r.status = place_value(shadow_list.size(), v);
            CMD_PREPEND:   r.status = place_value(0, v);
            CMD_INSERT_AT: r.status = place_value(int'(p), v);
            CMD_POP_FRONT: r.status = take_value(0, r.removed);
            CMD_REMOVE_AT: r.status = take_value(int'(p), r.removed);
            default: ;
        endcase
        r.entries_left = COUNT_W'(shadow_list.size());
        return r;
    endfunction

    // ---------------------------------------------------------------- result side
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request > 0)
            begin
                hold_len     = hold_request;
                hold_request = 0;
                result_ch.ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
            end
            else if (receiver_gaps && $urandom_range(99) < 20)
                result_ch.ready <= 1'b0;
            else
                result_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
        begin
            if (replies_due.size() == 0)
                report_mismatch("result transaction with no command outstanding");
            else
            begin
                reply_seen = replies_due.pop_front();
                if (result_ch.status !== reply_seen.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              result_ch.status, reply_seen.status));
                if (result_ch.removed_value !== reply_seen.removed)
                    report_mismatch($sformatf("removed_value got %0d want %0d",
                                              result_ch.removed_value, reply_seen.removed));
                if (result_ch.entry_count !== reply_seen.entries_left)
                    report_mismatch($sformatf("entry_count got %0d want %0d",
                                              result_ch.entry_count, reply_seen.entries_left));
            end
        end
    end

    // ---------------------------------------------------------------- command side
    task automatic send_command(input logic [CMD_W-1:0] c,
                                input logic signed [VALUE_W-1:0] v,
                                input logic [POS_W-1:0] p);
        int gap;
        gap = 0;
        if (sender_gaps && $urandom_range(99) < 25)
            gap = 1;
        if (gap > 0)
        begin
            request_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        request_ch.valid         <= 1'b1;
        request_ch.cmd           <= c;
        request_ch.item_value    <= v;
        request_ch.item_position <= p;
        @(posedge clk);
        while (request_ch.ready !== 1'b1)
            @(posedge clk);
        replies_due.push_back(step_shadow_list(c, v, p));
    endtask

    task automatic drain_results();
        int waited;
        waited = 0;
        request_ch.valid <= 1'b0;
        while (replies_due.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (replies_due.size() != 0)
        begin
            report_mismatch($sformatf("%0d results never arrived", replies_due.size()));
            replies_due.delete();
        end
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return $urandom;
        if (r < 75)
            return int'($urandom_range(2000)) - 1000;
        case ($urandom_range(7))
            0:       return VALUE_LIMIT;
            1:       return -VALUE_LIMIT;
            2:       return VALUE_LIMIT + 1;
            3:       return -VALUE_LIMIT - 1;
            4:       return MOST_NEG;
            5:       return MOST_POS;
            6:       return '0;
            default: return '1;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position(input bit for_insert);
        int n;
        n = shadow_list.size();
        if ($urandom_range(99) < 15)
            return POS_W'($urandom_range(0, POS_MAX));
        if (for_insert)
            return POS_W'($urandom_range(0, n));
        return (n == 0) ? '0 : POS_W'($urandom_range(0, n - 1));
    endfunction

    task automatic send_random_command(input int insert_pct);
        int r;
        logic [CMD_W-1:0] c;
        r = $urandom_range(99);
        if (r < 3)
            c = CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
        else if ($urandom_range(99) < insert_pct)
        begin
            case ($urandom_range(2))
                0:       c = CMD_APPEND;
                1:       c = CMD_PREPEND;
                default: c = CMD_INSERT_AT;
            endcase
        end
        else
            c = ($urandom_range(1)) ? CMD_POP_FRONT : CMD_REMOVE_AT;
        send_command(c, pick_value(),
                     pick_position(c != CMD_POP_FRONT && c != CMD_REMOVE_AT));
    endtask

    // ---------------------------------------------------------------- tests
    task automatic test_empty_list();
        send_command(CMD_POP_FRONT, '0, '0);
        send_command(CMD_REMOVE_AT, '0, '0);
        send_command(CMD_REMOVE_AT, MOST_NEG, POS_MAX);
    endtask

    task automatic test_value_limits();
        send_command(CMD_APPEND, VALUE_LIMIT, '0);
        send_command(CMD_APPEND, -VALUE_LIMIT, '0);
        send_command(CMD_PREPEND, VALUE_LIMIT + 1, '0);
        send_command(CMD_APPEND, -VALUE_LIMIT - 1, '0);
        send_command(CMD_INSERT_AT, MOST_NEG, '0);
        send_command(CMD_APPEND, MOST_POS, '0);
        send_command(CMD_PREPEND, '1, '0);
    endtask

    // list holds three entries on entry
    task automatic test_positions();
        send_command(CMD_INSERT_AT, 32'sd5, POS_MAX);
        send_command(CMD_INSERT_AT, 32'sd6, 7'd4);
        send_command(CMD_INSERT_AT, 32'sd7, 7'd3);    // insert at count = append
        send_command(CMD_INSERT_AT, 32'sd9, 7'd1);
        send_command(CMD_REMOVE_AT, '0, 7'd5);
        send_command(CMD_REMOVE_AT, '0, 7'd4);
        send_command(CMD_REMOVE_AT, '0, 7'd1);
        send_command(CMD_POP_FRONT, '0, '0);
    endtask

    task automatic test_unknown_commands();
        for (int c = CMD_SPARE_LO; c <= CMD_SPARE_HI; c++)
            send_command(CMD_W'(c), MOST_NEG, POS_MAX);
    endtask

    // alternate insert-heavy and remove-heavy phases so the list hits full and empty
    task automatic test_random_mix();
        int bias[6] = '{95, 10, 95, 50, 10, 80};
        foreach (bias[i])
        begin
            repeat (95) send_random_command(bias[i]);
            if (i == 2)
                drain_results();
        end
        drain_results();
    endtask

    task automatic test_no_idle();
        sender_gaps   = 1'b0;
        receiver_gaps = 1'b0;
        repeat (60) send_random_command(50);
        drain_results();
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    // result side stalls while commands keep coming; input must back up
    task automatic test_receiver_hold();
        hold_request = HOLD_LEN;
        repeat (20) send_random_command(60);
        drain_results();
    endtask

    initial
    begin
        rst_n                    <= 1'b0;
        request_ch.valid         <= 1'b0;
        request_ch.cmd           <= CMD_APPEND;
        request_ch.item_value    <= '0;
        request_ch.item_position <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_value_limits();
        test_positions();
        test_unknown_commands();
        drain_results();
        test_random_mix();
        test_no_idle();
        test_receiver_hold();

        drain_results();
        repeat (8) @(posedge clk);
        if (error_count == 0)
            $display("positional_list_buffer_tb: clean");
        else
            $display("positional_list_buffer_tb: errors");
        $finish;
    end

endmodule

/* positional_list_buffer.f */
rtl/core/plb_pkg.sv
rtl/core/plb_if.sv
rtl/core/plb_cells.sv
rtl/core/positional_list_buffer.sv
bench/positional_list_buffer_tb.sv
